// ----- sv/sra_pkg.sv -----
// Shared types and constants for the skyline rectangle allocator.
// Used by the window unit, the top level and the port checker; depends on nothing.
`timescale 1ns / 1ps

package sra_pkg;

	// Widths of the request and result fields.
	localparam int REQ_W    = 8;  // rect_width, rect_height
	localparam int HGT_W    = 8;  // one stored column height
	localparam int PAGE_O_W = 6;  // page_index
	localparam int POSX_W   = 7;  // pos_x
	localparam int POSY_W   = 7;  // pos_y

	// Stream payload widths; the tdata fields are padded to whole bytes.
	localparam int S_TDATA_W = 16;
	localparam int S_TUSER_W = 1;
	localparam int M_FLD_W   = PAGE_O_W + POSX_W + POSY_W;
	localparam int M_TDATA_W = 24;
	localparam int M_PAD_W   = M_TDATA_W - M_FLD_W;
	localparam int M_TUSER_W = 1;

	// Operation codes carried in s_tuser.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// Command for one column step of the window scan, registered alongside the column read data.
	typedef struct packed {
		logic pass_a;     // prefix pass, left to right
		logic pass_b;     // suffix pass, right to left
		logic first;      // rightmost scanned column of the suffix pass
		logic blk_start;  // column opens a block of rect_width columns
		logic win_ok;     // a window may start at this column
	} sra_step_t;

endpackage

// ----- sv/sra_window_unit.sv -----
// Window unit: finds the window of rect_width columns whose highest column is lowest.
// Holds the block prefix-max scratch memory and the shared max/compare datapath.
// Depends on sra_pkg.
`timescale 1ns / 1ps

module sra_window_unit #(
	parameter int PAGE_WIDTH  = 128,
	parameter int PAGE_HEIGHT = 128
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        init,
	input  sra_pkg::sra_step_t          step_s1,
	input  logic [$clog2(PAGE_WIDTH)-1:0] j_s1,
	input  logic [sra_pkg::HGT_W-1:0]   col_s1,
	input  logic [$clog2(PAGE_WIDTH)-1:0] scr_raddr,
	output logic                        found,
	output logic [sra_pkg::HGT_W-1:0]   best,
	output logic [$clog2(PAGE_WIDTH)-1:0] best_x
);

	localparam int COL_W = $clog2(PAGE_WIDTH);
	localparam int HW    = sra_pkg::HGT_W;
	localparam logic [HW-1:0] H_LIM = HW'(PAGE_HEIGHT);

	logic [HW-1:0]    scr_mem [PAGE_WIDTH];
	logic [HW-1:0]    scr_rd_q;
	logic [HW-1:0]    p_q;
	logic [HW-1:0]    s_q;
	logic             prev_start_q;
	logic             found_q;
	logic [HW-1:0]    best_q;
	logic [COL_W-1:0] best_x_q;

	logic [HW-1:0] p_new;
	logic [HW-1:0] s_new;
	logic [HW-1:0] cand;
	logic          take;

	// Running block maxima and the candidate window maximum.
	always_comb begin
		p_new = (step_s1.blk_start || (col_s1 > p_q)) ? col_s1 : p_q;
		s_new = (step_s1.first || prev_start_q || (col_s1 > s_q)) ? col_s1 : s_q;
		cand  = (s_new > scr_rd_q) ? s_new : scr_rd_q;
		// Scanning right to left, a tie moves the choice further left.
		take  = step_s1.pass_b && step_s1.win_ok && (cand < H_LIM) && (cand <= best_q);
	end

	// Scratch memory of block prefix maxima: written in the prefix pass.
	always_ff @(posedge clk) begin
		if (step_s1.pass_a) begin
			scr_mem[j_s1] <= p_new;
		end
		scr_rd_q <= scr_mem[scr_raddr];
	end

	// Running maxima carried from column to column.
	always_ff @(posedge clk) begin
		if (step_s1.pass_a) begin
			p_q <= p_new;
		end
		if (step_s1.pass_b) begin
			s_q <= s_new;
		end
	end

	// Best window of the current page.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_start_q <= 1'b0;
			found_q      <= 1'b0;
			best_q       <= H_LIM;
			best_x_q     <= '0;
		end else begin
			if (step_s1.pass_b) begin
				prev_start_q <= step_s1.blk_start;
			end
			if (init) begin
				found_q <= 1'b0;
				best_q  <= H_LIM;
			end else if (take) begin
				found_q  <= 1'b1;
				best_q   <= cand;
				best_x_q <= j_s1;
			end
		end
	end

	assign found  = found_q;
	assign best   = best_q;
	assign best_x = best_x_q;

endmodule

// ----- sv/skyline_rect_allocator.sv -----
// Skyline rectangle allocator: a clear sweeps the column memory, one column a cycle.
// An allocation runs a prefix pass and a suffix pass over each page tried, then raises
// the chosen columns and loads the result; one column read a cycle sets the pace.
// One transaction is in flight at a time; a finished result waits in the output register.
// After reset a clearing sweep of all PAGE_COUNT*PAGE_WIDTH columns runs before the first transaction.
// Top level; depends on sra_pkg and sra_window_unit.
`timescale 1ns / 1ps

module skyline_rect_allocator #(
	parameter int PAGE_COUNT  = 64,
	parameter int PAGE_WIDTH  = 128,
	parameter int PAGE_HEIGHT = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [sra_pkg::S_TDATA_W-1:0] s_tdata,  // rect_width, rect_height
	input  logic [sra_pkg::S_TUSER_W-1:0] s_tuser,  // operation
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [sra_pkg::M_TDATA_W-1:0] m_tdata,  // page_index, pos_x, pos_y, zero pad
	output logic [sra_pkg::M_TUSER_W-1:0] m_tuser   // full_res
);

	localparam int DEPTH  = PAGE_COUNT * PAGE_WIDTH;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int COL_W  = $clog2(PAGE_WIDTH);
	localparam int PG_W   = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam int RW     = sra_pkg::REQ_W;
	localparam int HW     = sra_pkg::HGT_W;
	localparam int PO_W   = sra_pkg::PAGE_O_W;
	localparam int PX_W   = sra_pkg::POSX_W;
	localparam int PY_W   = sra_pkg::POSY_W;
	localparam int PAD_W  = sra_pkg::M_PAD_W;

	localparam logic [COL_W-1:0]  J_LAST    = COL_W'(PAGE_WIDTH - 2);
	localparam logic [COL_W-1:0]  X_RIGHT   = COL_W'(PAGE_WIDTH - 1);
	localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(DEPTH - 1);
	localparam logic [ADDR_W-1:0] PAGE_STEP = ADDR_W'(PAGE_WIDTH);
	localparam logic [PG_W-1:0]   PG_LAST   = PG_W'(PAGE_COUNT - 1);
	localparam logic [RW:0]       W_LIM     = (RW + 1)'(PAGE_WIDTH);
	localparam logic [RW:0]       W_WIN     = (RW + 1)'(PAGE_WIDTH - 1);
	localparam logic [HW:0]       H_LIM     = (HW + 1)'(PAGE_HEIGHT);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PASS_A,
		ST_GAP_A,
		ST_PASS_B,
		ST_GAP_B,
		ST_DECIDE,
		ST_WRITE,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic                clr_op_q;
	logic [ADDR_W-1:0]   clr_addr_q;
	logic [RW-1:0]       w_q;
	logic [RW-1:0]       h_q;
	logic [PG_W-1:0]     page_q;
	logic [ADDR_W-1:0]   base_q;
	logic [COL_W-1:0]    j_q;
	logic [RW-1:0]       blk_q;
	logic [ADDR_W-1:0]   wptr_q;
	logic [RW-1:0]       rem_q;
	logic [HW-1:0]       wval_q;
	sra_pkg::sra_step_t  step_s1;
	logic [COL_W-1:0]    j_s1;
	logic [HW-1:0]       col_rd_s1;
	logic [PG_W-1:0]     r_page_q;
	logic [COL_W-1:0]    r_x_q;
	logic [HW-1:0]       r_y_q;
	logic                r_full_q;
	logic                m_tvalid_q;
	logic [PO_W-1:0]     o_page_q;
	logic [PX_W-1:0]     o_x_q;
	logic [PY_W-1:0]     o_y_q;
	logic                o_full_q;

	logic [HW-1:0]      col_mem [DEPTH];
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [HW-1:0]      mem_wdata;
	logic [ADDR_W-1:0]  rd_addr;
	logic [COL_W-1:0]   scr_raddr;
	sra_pkg::sra_step_t step_c;
	logic [RW:0]        win_end;
	logic               win_ok;
	logic               unit_found;
	logic [HW-1:0]      unit_best;
	logic [COL_W-1:0]   unit_best_x;
	logic               fits;
	logic [HW:0]        top_sum;
	logic               in_fire;
	logic               in_op;
	logic [RW-1:0]      in_w;
	logic [RW-1:0]      in_h;

	// Request fields and handshake.
	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign in_op    = s_tuser[0];
	assign in_w     = s_tdata[RW-1:0];
	assign in_h     = s_tdata[2*RW-1:RW];

	// Column step command, read addresses and write port.
	always_comb begin
		win_end   = (RW + 1)'(j_q) + {1'b0, w_q};
		win_ok    = (win_end <= W_WIN);
		scr_raddr = win_ok ? COL_W'(win_end - 1'b1) : '0;
		rd_addr   = base_q + ADDR_W'(j_q);
		step_c           = '0;
		step_c.pass_a    = (state_q == ST_PASS_A);
		step_c.pass_b    = (state_q == ST_PASS_B);
		step_c.first     = (state_q == ST_PASS_B) && (j_q == J_LAST);
		step_c.blk_start = (blk_q == '0);
		step_c.win_ok    = win_ok;
		mem_we    = (state_q == ST_CLEAR) || (state_q == ST_WRITE);
		mem_waddr = (state_q == ST_CLEAR) ? clr_addr_q : wptr_q;
		mem_wdata = (state_q == ST_CLEAR) ? '0 : wval_q;
		top_sum   = {1'b0, unit_best} + {1'b0, h_q};
		fits      = unit_found && (top_sum <= H_LIM);
	end

	// Column height memory.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			col_mem[mem_waddr] <= mem_wdata;
		end
		col_rd_s1 <= col_mem[rd_addr];
	end

	sra_window_unit #(
		.PAGE_WIDTH  (PAGE_WIDTH),
		.PAGE_HEIGHT (PAGE_HEIGHT)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.init      (state_q == ST_PASS_A),
		.step_s1   (step_s1),
		.j_s1      (j_s1),
		.col_s1    (col_rd_s1),
		.scr_raddr (scr_raddr),
		.found     (unit_found),
		.best      (unit_best),
		.best_x    (unit_best_x)
	);

	// Sequencer, scan counters and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_op_q   <= 1'b0;
			clr_addr_q <= '0;
			w_q        <= '0;
			h_q        <= '0;
			page_q     <= '0;
			base_q     <= '0;
			j_q        <= '0;
			blk_q      <= '0;
			wptr_q     <= '0;
			rem_q      <= '0;
			wval_q     <= '0;
			step_s1    <= '0;
			j_s1       <= '0;
			r_page_q   <= '0;
			r_x_q      <= '0;
			r_y_q      <= '0;
			r_full_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
			o_page_q   <= '0;
			o_x_q      <= '0;
			o_y_q      <= '0;
			o_full_q   <= 1'b0;
		end else begin
			step_s1 <= step_c;
			j_s1    <= j_q;
			if (m_tvalid_q && m_tready && (state_q != ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (clr_addr_q == CLR_LAST) begin
						clr_addr_q <= '0;
						clr_op_q   <= 1'b0;
						r_page_q   <= '0;
						r_x_q      <= '0;
						r_y_q      <= '0;
						r_full_q   <= 1'b0;
						state_q    <= clr_op_q ? ST_DONE : ST_IDLE;
					end else begin
						clr_addr_q <= clr_addr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						w_q      <= in_w;
						h_q      <= in_h;
						r_page_q <= '0;
						r_x_q    <= '0;
						r_y_q    <= '0;
						if (in_op == sra_pkg::OP_CLEAR) begin
							clr_op_q   <= 1'b1;
							clr_addr_q <= '0;
							state_q    <= ST_CLEAR;
						end else if (in_w == '0) begin
							// Empty window: first page, rightmost start, nothing raised.
							if ((HW + 1)'(in_h) <= H_LIM) begin
								r_x_q    <= X_RIGHT;
								r_full_q <= 1'b0;
							end else begin
								r_full_q <= 1'b1;
							end
							state_q <= ST_DONE;
						end else if ({1'b0, in_w} >= W_LIM) begin
							r_full_q <= 1'b1;
							state_q  <= ST_DONE;
						end else begin
							page_q  <= '0;
							base_q  <= '0;
							j_q     <= '0;
							blk_q   <= '0;
							state_q <= ST_PASS_A;
						end
					end
				end
				ST_PASS_A: begin
					// The block counter keeps the offset of the last column for the next pass.
					if (j_q == J_LAST) begin
						state_q <= ST_GAP_A;
					end else begin
						j_q   <= j_q + 1'b1;
						blk_q <= (blk_q == (w_q - 1'b1)) ? '0 : blk_q + 1'b1;
					end
				end
				ST_GAP_A: begin
					state_q <= ST_PASS_B;
				end
				ST_PASS_B: begin
					if (j_q == '0) begin
						state_q <= ST_GAP_B;
					end else begin
						j_q   <= j_q - 1'b1;
						blk_q <= (blk_q == '0) ? (w_q - 1'b1) : (blk_q - 1'b1);
					end
				end
				ST_GAP_B: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (fits) begin
						r_page_q <= page_q;
						r_x_q    <= unit_best_x;
						r_y_q    <= unit_best;
						r_full_q <= 1'b0;
						wptr_q   <= base_q + ADDR_W'(unit_best_x);
						rem_q    <= w_q;
						wval_q   <= top_sum[HW-1:0];
						state_q  <= ST_WRITE;
					end else if (page_q == PG_LAST) begin
						r_page_q <= '0;
						r_x_q    <= '0;
						r_y_q    <= '0;
						r_full_q <= 1'b1;
						state_q  <= ST_DONE;
					end else begin
						page_q  <= page_q + 1'b1;
						base_q  <= base_q + PAGE_STEP;
						j_q     <= '0;
						blk_q   <= '0;
						state_q <= ST_PASS_A;
					end
				end
				ST_WRITE: begin
					wptr_q <= wptr_q + 1'b1;
					rem_q  <= rem_q - 1'b1;
					if (rem_q == RW'(1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						o_page_q   <= PO_W'(r_page_q);
						o_x_q      <= PX_W'(r_x_q);
						o_y_q      <= PY_W'(r_y_q);
						o_full_q   <= r_full_q;
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, o_y_q, o_x_q, o_page_q};
	assign m_tuser  = o_full_q;

endmodule

// ----- sv/sra_checker.sv -----
// Port checker for the skyline rectangle allocator, bound to the top level.
// Sees only the stream ports; depends on sra_pkg.
`timescale 1ns / 1ps

module sra_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [sra_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [sra_pkg::M_TUSER_W-1:0] m_tuser
);

	// One transaction at a time: the input closes right after an accept.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input still ready after an accepted transaction");

	// No result can appear in the cycle right after a request is taken.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !$rose(m_tvalid))
		else $error("result appeared without any work");

	// A full answer carries no placement.
	a_full_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
		else $error("full result with nonzero placement");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("result changed while stalled");

endmodule

bind skyline_rect_allocator sra_checker u_sra_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
